FILE: src/pss_pkg.sv
// Package for the peak separation statistics block.
// Holds opcodes, statistic selects and widths shared by the interfaces and the top level.
`default_nettype none
package pss_pkg;
  localparam int OPCODE_W  = 2;
  localparam int SELECT_W  = 3;
  localparam int INDEX_W   = 6;
  localparam int ROW_OUT_W = 6;
  localparam int BIN_W     = 4;
  localparam int RATIO_W   = 17;
  localparam int DATA_W    = 64;
  localparam int CNT_W     = 32;
  localparam int FRAC_BITS = 16;
  localparam int SCALE     = 10;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [SELECT_W-1:0] {
    SEL_SUM    = 3'd0,
    SEL_TOP    = 3'd1,
    SEL_SECOND = 3'd2,
    SEL_HIST   = 3'd3,
    SEL_OBS    = 3'd4,
    SEL_MAX    = 3'd5,
    SEL_MIN    = 3'd6,
    SEL_NONE   = 3'd7
  } select_t;

  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
endpackage
`default_nettype wire

FILE: src/pss_if.sv
// Valid/ready channel interfaces for the peak separation statistics block.
// Depends on pss_pkg.
`default_nettype none
interface pss_in_if #(parameter int ENERGY_BITS = 48);
  logic                         valid;
  logic                         ready;
  logic [pss_pkg::OPCODE_W-1:0] opcode;
  logic signed [ENERGY_BITS-1:0] energy;
  logic [pss_pkg::SELECT_W-1:0] stat_select;
  logic [pss_pkg::INDEX_W-1:0]  stat_index;
  modport source (output valid, opcode, energy, stat_select, stat_index, input ready);
  modport sink (input valid, opcode, energy, stat_select, stat_index, output ready);
endinterface

interface pss_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic                          top_valid;
  logic [pss_pkg::ROW_OUT_W-1:0] top_row;
  logic                          second_valid;
  logic [pss_pkg::ROW_OUT_W-1:0] second_row;
  logic [pss_pkg::BIN_W-1:0]     ratio_bin;
  logic [pss_pkg::RATIO_W-1:0]   ratio_value;
  logic [pss_pkg::DATA_W-1:0]    read_data;
  modport source (output valid, result_kind, top_valid, top_row, second_valid, second_row,
                  ratio_bin, ratio_value, read_data, input ready);
  modport sink (input valid, result_kind, top_valid, top_row, second_valid, second_row,
                ratio_bin, ratio_value, read_data, output ready);
endinterface
`default_nettype wire

FILE: src/peak_separation_stats.sv
// Top level of the peak separation statistics block: row sums, peak tracking,
// hit counters, ratio divider and histogram. Depends on pss_pkg and pss_if.
// A push passes through accept, row sum read, and add and write back.
// A read registers the memory word, then the result word; input stays blocked until it is taken.
// After the last push of an observation with a peak come the hit counter updates, a 17-step
// division and a 10-step bin accumulation on the shared subtractor, the histogram and the output.
// Reset and a clear start a clearing pass over all memory entries; no input taken.
`default_nettype none
module peak_separation_stats #(
  parameter int NUM_ROWS    = 64,
  parameter int NUM_BINS    = 11,
  parameter int ENERGY_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pss_in_if.sink    in_ch,
  pss_out_if.source out_ch
);
  import pss_pkg::*;

  localparam int RW  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int EW  = ENERGY_BITS - 1;
  localparam int CLW = (NUM_ROWS > NUM_BINS) ? RW : BW;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PUSH_RD, S_PUSH_WR, S_READ_RD, S_READ_OUT,
    S_TOP_RD, S_TOP_WR, S_SEC_RD, S_SEC_WR, S_DIV, S_BIN, S_HIST_RD, S_HIST_WR, S_OUT
  } state_t;

  // Memories.
  logic [DATA_W-1:0] sum_mem  [NUM_ROWS];
  logic [CNT_W-1:0]  top_mem  [NUM_ROWS];
  logic [CNT_W-1:0]  sec_mem  [NUM_ROWS];
  logic [CNT_W-1:0]  hist_mem [NUM_BINS];

  state_t state_r;
  logic [CLW-1:0]    clr_r;
  logic [RW-1:0]     pos_r;
  logic [EW-1:0]     best_r, run_r, e_r;
  logic              best_f_r, run_f_r;
  logic [RW-1:0]     best_row_r, run_row_r;
  logic [CNT_W-1:0]  obs_r;
  logic [RATIO_W-1:0] max_r, min_r;
  logic [SELECT_W-1:0] sel_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [DATA_W-1:0] rd_sum_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic [4:0]        step_r;
  logic [EW:0]       rem_r;
  logic [RATIO_W-1:0] q_r;
  logic [BIN_W-1:0]  cnt_r;
  logic [BW-1:0]     bin_r;
  logic              out_valid_r, out_kind_r, out_tv_r, out_sv_r;
  logic [ROW_OUT_W-1:0] out_tr_r, out_sr_r;
  logic [BIN_W-1:0]  out_bin_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic [DATA_W-1:0] out_data_r;

  // Shared subtractor: restoring division steps, then the bin accumulation,
  // which adds the second value each step and takes off the top value when it fits.
  logic [EW:0] rem_sh, rem_diff;
  logic        rem_ge;
  assign rem_sh   = (state_r == S_BIN) ? rem_r + {1'b0, run_r} :
                    (step_r == 5'd0) ? {1'b0, run_r} : {rem_r[EW-1:0], 1'b0};
  assign rem_diff = rem_sh - {1'b0, best_r};
  assign rem_ge   = rem_sh >= {1'b0, best_r};

  // Bin is the accumulated count floor(10*second/top), clamped to the last bin.
  logic [BW-1:0]      bin_nxt;
  assign bin_nxt = (32'(cnt_r) > NUM_BINS - 1) ? BW'(NUM_BINS - 1) : BW'(cnt_r);

  // Clamped energy and saturating row sum.
  logic [EW-1:0]     e_in;
  logic [DATA_W:0]   sum_add;
  assign e_in    = in_ch.energy[ENERGY_BITS-1] ? '0 : in_ch.energy[EW-1:0];
  assign sum_add = {1'b0, rd_sum_r} + (DATA_W + 1)'(e_r);

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;

  // Memory access.
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      if (32'(clr_r) < NUM_ROWS) begin
        sum_mem[clr_r[RW-1:0]] <= '0;
        top_mem[clr_r[RW-1:0]] <= '0;
        sec_mem[clr_r[RW-1:0]] <= '0;
      end
      if (32'(clr_r) < NUM_BINS) hist_mem[clr_r[BW-1:0]] <= '0;
    end
    if (state_r == S_PUSH_WR)
      sum_mem[pos_r] <= sum_add[DATA_W] ? '1 : sum_add[DATA_W-1:0];
    if (state_r == S_TOP_WR)
      top_mem[best_row_r] <= (rd_cnt_r == CNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
    if (state_r == S_SEC_WR)
      sec_mem[run_row_r] <= (rd_cnt_r == CNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
    if (state_r == S_HIST_WR)
      hist_mem[bin_r] <= (rd_cnt_r == CNT_MAX) ? rd_cnt_r : rd_cnt_r + 1'b1;
    // Read port, registered.
    unique case (state_r)
      S_PUSH_RD: rd_sum_r <= sum_mem[pos_r];
      S_TOP_RD:  rd_cnt_r <= top_mem[best_row_r];
      S_SEC_RD:  rd_cnt_r <= sec_mem[run_row_r];
      S_HIST_RD: rd_cnt_r <= hist_mem[bin_nxt];
      S_READ_RD: begin
        rd_sum_r <= sum_mem[idx_r[RW-1:0]];
        case (sel_r)
          SEL_TOP:  rd_cnt_r <= top_mem[idx_r[RW-1:0]];
          SEL_HIST: rd_cnt_r <= hist_mem[idx_r[BW-1:0]];
          default:  rd_cnt_r <= sec_mem[idx_r[RW-1:0]];
        endcase
      end
      default: ;
    endcase
  end

  // Sequencer, statistics registers and output word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      pos_r <= '0; best_r <= '0; run_r <= '0;
      best_f_r <= 1'b0; run_f_r <= 1'b0;
      best_row_r <= '0; run_row_r <= '0;
      obs_r <= '0; max_r <= '0; min_r <= RATIO_ONE;
      step_r <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (32'(clr_r) >= NUM_ROWS - 1 && 32'(clr_r) >= NUM_BINS - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          sel_r <= in_ch.stat_select;
          idx_r <= in_ch.stat_index;
          e_r   <= e_in;
          case (opcode_t'(in_ch.opcode))
            OP_PUSH: begin
              state_r <= S_PUSH_RD;
              if (e_in > best_r) begin
                run_r <= best_r; run_row_r <= best_row_r; run_f_r <= best_f_r;
                best_r <= e_in; best_row_r <= pos_r; best_f_r <= 1'b1;
              end else if (e_in > run_r) begin
                run_r <= e_in; run_row_r <= pos_r; run_f_r <= 1'b1;
              end
            end
            OP_READ: state_r <= S_READ_RD;
            OP_CLEAR: begin
              state_r <= S_CLEAR; clr_r <= '0;
              pos_r <= '0; best_r <= '0; run_r <= '0;
              best_f_r <= 1'b0; run_f_r <= 1'b0;
              best_row_r <= '0; run_row_r <= '0;
              obs_r <= '0; max_r <= '0; min_r <= RATIO_ONE;
            end
            default: ;
          endcase
        end
        S_PUSH_RD: state_r <= S_PUSH_WR;
        S_PUSH_WR: begin
          if (32'(pos_r) == NUM_ROWS - 1) begin
            pos_r <= '0;
            obs_r <= (obs_r == CNT_MAX) ? obs_r : obs_r + 1'b1;
            state_r <= best_f_r ? S_TOP_RD : S_OUT;
          end else begin
            pos_r <= pos_r + 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_TOP_RD: state_r <= S_TOP_WR;
        S_TOP_WR: state_r <= run_f_r ? S_SEC_RD : S_DIV;
        S_SEC_RD: state_r <= S_SEC_WR;
        S_SEC_WR: state_r <= S_DIV;
        S_DIV: begin
          q_r <= {q_r[RATIO_W-2:0], rem_ge};
          if (step_r == 5'(FRAC_BITS)) begin
            step_r  <= '0;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_BIN;
          end else begin
            rem_r  <= rem_ge ? rem_diff : rem_sh;
            step_r <= step_r + 1'b1;
          end
        end
        // Ten accumulation steps count how many times the top value fits.
        S_BIN: begin
          rem_r <= rem_ge ? rem_diff : rem_sh;
          cnt_r <= cnt_r + BIN_W'(rem_ge);
          if (step_r == 5'(SCALE - 1)) begin
            step_r  <= '0;
            state_r <= S_HIST_RD;
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        S_HIST_RD: begin
          bin_r <= bin_nxt;
          state_r <= S_HIST_WR;
        end
        S_HIST_WR: begin
          if (q_r > max_r) max_r <= q_r;
          if (q_r < min_r) min_r <= q_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= 1'b0;
          out_tv_r    <= best_f_r;
          out_tr_r    <= best_f_r ? ROW_OUT_W'(best_row_r) : '0;
          out_sv_r    <= run_f_r;
          out_sr_r    <= run_f_r ? ROW_OUT_W'(run_row_r) : '0;
          out_bin_r   <= best_f_r ? BIN_W'(bin_r) : '0;
          out_ratio_r <= best_f_r ? q_r : '0;
          out_data_r  <= '0;
          best_r <= '0; run_r <= '0; best_f_r <= 1'b0; run_f_r <= 1'b0;
          best_row_r <= '0; run_row_r <= '0;
          state_r <= S_IDLE;
        end
        S_READ_RD: state_r <= S_READ_OUT;
        S_READ_OUT: begin
          out_valid_r <= 1'b1;
          out_kind_r  <= 1'b1;
          out_tv_r <= 1'b0; out_tr_r <= '0; out_sv_r <= 1'b0; out_sr_r <= '0;
          out_bin_r <= '0; out_ratio_r <= '0;
          case (select_t'(sel_r))
            SEL_SUM:    out_data_r <= (32'(idx_r) < NUM_ROWS) ? rd_sum_r : '0;
            SEL_TOP, SEL_SECOND:
              out_data_r <= (32'(idx_r) < NUM_ROWS) ? DATA_W'(rd_cnt_r) : '0;
            SEL_HIST:   out_data_r <= (32'(idx_r) < NUM_BINS) ? DATA_W'(rd_cnt_r) : '0;
            SEL_OBS:    out_data_r <= DATA_W'(obs_r);
            SEL_MAX:    out_data_r <= DATA_W'(max_r);
            SEL_MIN:    out_data_r <= DATA_W'(min_r);
            default:    out_data_r <= '0;
          endcase
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.top_valid    = out_tv_r;
  assign out_ch.top_row      = out_tr_r;
  assign out_ch.second_valid = out_sv_r;
  assign out_ch.second_row   = out_sr_r;
  assign out_ch.ratio_bin    = out_bin_r;
  assign out_ch.ratio_value  = out_ratio_r;
  assign out_ch.read_data    = out_data_r;
endmodule
`default_nettype wire

FILE: verif/peak_separation_stats_chk.sv
// Checker for the peak separation statistics block: watches both channels,
// predicts every result word and compares it field by field. Depends on pss_pkg and pss_if.
`default_nettype none
module peak_separation_stats_chk #(
  parameter int NUM_ROWS    = 64,
  parameter int NUM_BINS    = 11,
  parameter int ENERGY_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pss_in_if         in_ch,
  pss_out_if        out_ch,
  output int        fail_count,
  output int        pending_count
);
  import pss_pkg::*;

  typedef struct packed {
    logic                 result_kind;
    logic                 top_valid;
    logic [ROW_OUT_W-1:0] top_row;
    logic                 second_valid;
    logic [ROW_OUT_W-1:0] second_row;
    logic [BIN_W-1:0]     ratio_bin;
    logic [RATIO_W-1:0]   ratio_value;
    logic [DATA_W-1:0]    read_data;
  } stat_word_t;

  // Predicted block state.
  logic [63:0]        sum_mem [NUM_ROWS];
  logic [CNT_W-1:0]   top_cnt [NUM_ROWS];
  logic [CNT_W-1:0]   sec_cnt [NUM_ROWS];
  logic [CNT_W-1:0]   hist_cnt [NUM_BINS];
  logic [CNT_W-1:0]   obs_cnt;
  logic [RATIO_W-1:0] ratio_hi, ratio_lo;
  int                 row_pos;
  logic [63:0]        peak_val, runner_val;
  bit                 peak_found, runner_found;
  int                 peak_row, runner_row;

  stat_word_t expected_words[$];

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  task automatic clear_state();
    for (int i = 0; i < NUM_ROWS; i++) begin
      sum_mem[i] = '0;
      top_cnt[i] = '0;
      sec_cnt[i] = '0;
    end
    for (int i = 0; i < NUM_BINS; i++) hist_cnt[i] = '0;
    obs_cnt = '0;
    ratio_hi = '0;
    ratio_lo = RATIO_ONE;
    row_pos = 0;
    peak_val = '0;
    runner_val = '0;
    peak_found = 0;
    runner_found = 0;
    peak_row = 0;
    runner_row = 0;
  endtask

  // Updates the prediction for one accepted input word.
  task automatic predict_word(logic [OPCODE_W-1:0] op, logic [ENERGY_BITS-1:0] en,
                              logic [SELECT_W-1:0] sel, logic [INDEX_W-1:0] idx);
    stat_word_t w;
    logic [63:0] e, s;
    logic [RATIO_W-1:0] q;
    int bin;
    w = '0;
    case (opcode_t'(op))
      OP_PUSH: begin
        e = en[ENERGY_BITS-1] ? 64'd0 : 64'(en);
        s = sum_mem[row_pos] + e;
        sum_mem[row_pos] = (s < sum_mem[row_pos]) ? '1 : s;
        if (e > peak_val) begin
          runner_val = peak_val;
          runner_row = peak_row;
          runner_found = peak_found;
          peak_val = e;
          peak_row = row_pos;
          peak_found = 1;
        end else if (e > runner_val) begin
          runner_val = e;
          runner_row = row_pos;
          runner_found = 1;
        end
        if (row_pos + 1 < NUM_ROWS) begin
          row_pos++;
        end else begin
          obs_cnt = sat_inc(obs_cnt);
          if (peak_found) top_cnt[peak_row] = sat_inc(top_cnt[peak_row]);
          if (runner_found) sec_cnt[runner_row] = sat_inc(sec_cnt[runner_row]);
          q = '0;
          bin = 0;
          if (peak_found) begin
            // Runner never exceeds the peak, so the quotients stay in range.
            q = RATIO_W'((128'(runner_val) << FRAC_BITS) / 128'(peak_val));
            bin = int'((128'(runner_val) * SCALE) / 128'(peak_val));
            if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
            hist_cnt[bin] = sat_inc(hist_cnt[bin]);
            if (q > ratio_hi) ratio_hi = q;
            if (q < ratio_lo) ratio_lo = q;
          end
          w.top_valid = peak_found;
          w.top_row = peak_found ? ROW_OUT_W'(peak_row) : '0;
          w.second_valid = runner_found;
          w.second_row = runner_found ? ROW_OUT_W'(runner_row) : '0;
          w.ratio_bin = BIN_W'(bin);
          w.ratio_value = q;
          expected_words.push_back(w);
          row_pos = 0;
          peak_val = '0;
          runner_val = '0;
          peak_found = 0;
          runner_found = 0;
          peak_row = 0;
          runner_row = 0;
        end
      end
      OP_READ: begin
        w.result_kind = 1'b1;
        case (select_t'(sel))
          SEL_SUM:    if (idx < NUM_ROWS) w.read_data = sum_mem[idx];
          SEL_TOP:    if (idx < NUM_ROWS) w.read_data = 64'(top_cnt[idx]);
          SEL_SECOND: if (idx < NUM_ROWS) w.read_data = 64'(sec_cnt[idx]);
          SEL_HIST:   if (idx < NUM_BINS) w.read_data = 64'(hist_cnt[idx]);
          SEL_OBS:    w.read_data = 64'(obs_cnt);
          SEL_MAX:    w.read_data = 64'(ratio_hi);
          SEL_MIN:    w.read_data = 64'(ratio_lo);
          default:    w.read_data = '0;
        endcase
        expected_words.push_back(w);
      end
      OP_CLEAR: clear_state();
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Compares one result word against the oldest expectation.
  task automatic compare_word(stat_word_t got);
    stat_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected word", 64'(got.result_kind), '0);
      return;
    end
    want = expected_words.pop_front();
    if (got.result_kind !== want.result_kind)
      report_mismatch("result_kind", 64'(got.result_kind), 64'(want.result_kind));
    if (got.top_valid !== want.top_valid)
      report_mismatch("top_valid", 64'(got.top_valid), 64'(want.top_valid));
    if (got.top_row !== want.top_row)
      report_mismatch("top_row", 64'(got.top_row), 64'(want.top_row));
    if (got.second_valid !== want.second_valid)
      report_mismatch("second_valid", 64'(got.second_valid), 64'(want.second_valid));
    if (got.second_row !== want.second_row)
      report_mismatch("second_row", 64'(got.second_row), 64'(want.second_row));
    if (got.ratio_bin !== want.ratio_bin)
      report_mismatch("ratio_bin", 64'(got.ratio_bin), 64'(want.ratio_bin));
    if (got.ratio_value !== want.ratio_value)
      report_mismatch("ratio_value", 64'(got.ratio_value), 64'(want.ratio_value));
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    clear_state();
  end

  // Both channels are sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        compare_word({out_ch.result_kind, out_ch.top_valid, out_ch.top_row,
                      out_ch.second_valid, out_ch.second_row, out_ch.ratio_bin,
                      out_ch.ratio_value, out_ch.read_data});
      if (in_ch.valid && in_ch.ready)
        predict_word(in_ch.opcode, in_ch.energy, in_ch.stat_select, in_ch.stat_index);
      pending_count = expected_words.size();
    end
  end
endmodule
`default_nettype wire

FILE: verif/peak_separation_stats_tb.sv
// Testbench top for the peak separation statistics block: drives words, stalls
// the result channel and gives the verdict. Depends on pss_pkg, pss_if and the checker.
`default_nettype none
module peak_separation_stats_tb;
  import pss_pkg::*;

  localparam int NUM_ROWS    = 64;
  localparam int NUM_BINS    = 11;
  localparam int ENERGY_BITS = 48;
  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count;
  int   cycle_count = 0;
  bit   calm_phase = 0;
  bit   hold_off = 0;

  pss_in_if #(.ENERGY_BITS(ENERGY_BITS)) in_ch ();
  pss_out_if out_ch ();

  peak_separation_stats #(.NUM_ROWS(NUM_ROWS), .NUM_BINS(NUM_BINS),
                          .ENERGY_BITS(ENERGY_BITS)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  peak_separation_stats_chk #(.NUM_ROWS(NUM_ROWS), .NUM_BINS(NUM_BINS),
                              .ENERGY_BITS(ENERGY_BITS)) i_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count));

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** peak_separation_stats: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, none in the calm phase, and one long hold-off.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(negedge clk);
        hold_off = 0;
      end
      out_ch.ready <= calm_phase || ($urandom_range(99) >= 24);
    end
  end

  // Sends one word and waits until it is taken.
  task automatic send_word(opcode_t op, logic [ENERGY_BITS-1:0] en,
                           select_t sel, logic [INDEX_W-1:0] idx);
    while (!calm_phase && $urandom_range(99) < 24) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.energy <= en;
    in_ch.stat_select <= sel;
    in_ch.stat_index <= idx;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  function automatic logic [ENERGY_BITS-1:0] rand_energy(int mode);
    logic [63:0] r;
    r = {$urandom, $urandom};
    case (mode)
      0: return '0;
      1: return {1'b1, r[ENERGY_BITS-2:0]};
      2: return {1'b0, {(ENERGY_BITS-1){1'b1}}};
      3: return ENERGY_BITS'($urandom_range(20));
      4: return ENERGY_BITS'(r[ENERGY_BITS-2:0] >> $urandom_range(ENERGY_BITS-2));
      default: return {1'b0, r[ENERGY_BITS-2:0]};
    endcase
  endfunction

  task automatic send_observation(int mode);
    for (int i = 0; i < NUM_ROWS; i++)
      send_word(OP_PUSH, rand_energy(mode < 0 ? $urandom_range(6) : mode),
                SEL_SUM, INDEX_W'($urandom));
  endtask

  task automatic read_everything();
    for (int s = 0; s <= SEL_NONE; s++)
      send_word(OP_READ, '0, select_t'(s), INDEX_W'($urandom_range(63)));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PUSH;
    in_ch.energy = '0;
    in_ch.stat_select = SEL_SUM;
    in_ch.stat_index = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: all-zero, ties, maximum energies, unknown opcode, clear.
    send_observation(0);
    for (int i = 0; i < NUM_ROWS; i++)
      send_word(OP_PUSH, (i == 5 || i == 9) ? ENERGY_BITS'(77) : '0, SEL_SUM, '0);
    send_word(OP_NONE, '1, SEL_NONE, '1);
    send_observation(2);
    read_everything();
    send_word(OP_READ, '0, SEL_HIST, 6'd63);
    send_word(OP_READ, '0, SEL_SUM, 6'd63);
    send_word(OP_CLEAR, '1, SEL_NONE, '1);
    read_everything();

    // Random traffic; mostly full observations with interleaved reads.
    for (int n = 0; n < 23; n++) begin
      calm_phase = (n >= 8 && n < 11);
      if (n == 14) hold_off = 1;
      for (int i = 0; i < NUM_ROWS; i++) begin
        if ($urandom_range(15) == 0)
          send_word(OP_READ, '0, select_t'($urandom_range(7)), INDEX_W'($urandom));
        if ($urandom_range(300) == 0)
          send_word(opcode_t'($urandom_range(2, 3)), '0, SEL_SUM, '0);
        send_word(OP_PUSH, rand_energy(n % 3 == 0 ? 5 : -1), SEL_SUM, '0);
      end
      if (n % 5 == 4) read_everything();
    end
    calm_phase = 0;
    for (int i = 0; i < NUM_ROWS; i++) send_word(OP_READ, '0, SEL_TOP, INDEX_W'(i));
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("** peak_separation_stats: PASSED **");
    else
      $display("** peak_separation_stats: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

FILE: peak_separation_stats.f
src/pss_pkg.sv
src/pss_if.sv
src/peak_separation_stats.sv
verif/peak_separation_stats_chk.sv
verif/peak_separation_stats_tb.sv
